@@ rtl/etfc_pkg.sv @@
`timescale 1ns / 1ps

package etfc_pkg;

  // Atom count bound and bracket store geometry
  localparam int MAX_ATOMS = 256;
  localparam int IDX_W     = 10;
  localparam int LIM_W     = 14;
  localparam logic [LIM_W-1:0] IDX_LIMIT = LIM_W'(3 * MAX_ATOMS);
  localparam int NUM_SLOTS = 81;
  localparam int SLOT_W    = 7;
  localparam int SUM_W     = 64;

  // Item function codes
  localparam logic [1:0] FUNC_ACC   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_SCALE = 1'b0;
  localparam logic CFG_SYM   = 1'b1;
  localparam logic [31:0] SCALE_RESET = 32'd1048576;

  typedef struct packed {
    logic [1:0]         func;
    logic [IDX_W-1:0]   first_index;
    logic [IDX_W-1:0]   second_index;
    logic signed [31:0] fc_value;
    logic signed [31:0] rel_x;
    logic signed [31:0] rel_y;
    logic signed [31:0] rel_z;
    logic [1:0]         read_i;
    logic [1:0]         read_j;
    logic [1:0]         read_k;
    logic [1:0]         read_l;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] elastic_value;
    logic               saturated;
  } out_item_t;

  // Request from the sequencer to the bracket store
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic              clr;
    logic [SLOT_W-1:0] addr;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_RND,
    ST_ADD,
    ST_RISSUE,
    ST_RACC,
    ST_FABS,
    ST_FMUL,
    ST_FOUT
  } state_t;

  function automatic logic [SLOT_W-1:0] slot(input logic [1:0] a, input logic [1:0] b,
                                             input logic [1:0] k, input logic [1:0] l);
    slot = SLOT_W'(a * 27 + b * 9 + k * 3 + l);
  endfunction

  // Index modulo 3: base-4 digits all weigh 1 modulo 3
  function automatic logic [1:0] mod3(input logic [IDX_W-1:0] x);
    logic [3:0] s;
    s = 4'd0;
    for (int i = 0; i < IDX_W / 2; i++) s = s + {2'b00, x[2*i +: 2]};
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: mod3 = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       mod3 = 2'd1;
      default:                              mod3 = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] clamp_idx(input logic [1:0] v);
    clamp_idx = (v == 2'd3) ? 2'd2 : v;
  endfunction

  // Symmetry table: position in ijkl taken by each leg of permutation n
  function automatic logic [7:0] sym_perm(input logic [2:0] n);
    case (n)
      3'd0:    sym_perm = {2'd0, 2'd1, 2'd2, 2'd3};
      3'd1:    sym_perm = {2'd1, 2'd0, 2'd2, 2'd3};
      3'd2:    sym_perm = {2'd0, 2'd1, 2'd3, 2'd2};
      3'd3:    sym_perm = {2'd1, 2'd0, 2'd3, 2'd2};
      3'd4:    sym_perm = {2'd2, 2'd3, 2'd0, 2'd1};
      3'd5:    sym_perm = {2'd3, 2'd2, 2'd0, 2'd1};
      3'd6:    sym_perm = {2'd2, 2'd3, 2'd1, 2'd0};
      default: sym_perm = {2'd3, 2'd2, 2'd1, 2'd0};
    endcase
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    mag32 = x[31] ? 32'(-x) : 32'(x);
  endfunction

endpackage

@@ rtl/elastic_tensor_from_force_constants.sv @@
`timescale 1ns / 1ps

// Elastic constants from harmonic force constants.
// Command channel: an item on cmd is taken at a clock edge with start high
// and busy low. func selects accumulate, clear or read.
// Accumulate: nine terms phi*r_k*r_l go into the bracket sums, each term
// through three 32x32 multiply passes, a rounding step and a
// read-modify-write of the sum store.
// Clear: takes effect at the accepting edge, busy stays low.
// Read: 3 bracket reads (24 with symmetrization), each issued and then
// accumulated, then magnitude, three 24x32 scale passes and rounding;
// result_strobe is registered from the final state ST_FOUT and is high for
// exactly one cycle; result holds until the next read finishes. The receiver cannot stall it.
// Accumulates with an index at or beyond 3*MAX_ATOMS and func 3 are dropped.
// Configuration: cfg_we writes cfg_data into register cfg_index at once;
// write only while busy is low and no result is pending.
// Reset (rst, synchronous) empties all sums and the overflow flag, and
// restores scale 1.0 and symmetrization off.

module elastic_tensor_from_force_constants (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  etfc_pkg::in_item_t   cmd,
  output logic                 result_strobe,
  output etfc_pkg::out_item_t  result,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data
);
  import etfc_pkg::*;

  state_t state, state_next;

  logic [31:0]        scale_factor;
  logic               symmetrize_enable;
  logic               overflow_seen;

  in_item_t           cur;
  logic [1:0]         a_co, b_co, kx, lx;
  logic [63:0]        m1, p0, p1;
  logic signed [63:0] term;
  logic signed [71:0] sum_acc;
  logic [71:0]        mag;
  logic               neg_q;
  logic [103:0]       prod;
  logic [2:0]         perm_cnt;
  logic [1:0]         part_cnt;
  logic [1:0]         chunk_cnt;
  logic               sym_q;
  logic [1:0]         ix [4];

  mem_req_t           req;
  logic [SUM_W-1:0]   wdata;
  logic [SUM_W-1:0]   rdata;

  logic               accept;
  logic               acc_ok;
  logic [SLOT_W-1:0]  acc_slot;
  logic [SLOT_W-1:0]  read_slot;
  logic               last_term;
  logic               last_combo;

  etfc_sum_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign acc_ok = ({{(LIM_W-IDX_W){1'b0}}, cmd.first_index} < IDX_LIMIT) &&
                  ({{(LIM_W-IDX_W){1'b0}}, cmd.second_index} < IDX_LIMIT);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor      <= SCALE_RESET;
      symmetrize_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE: scale_factor      <= cfg_data;
        CFG_SYM:   symmetrize_enable <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  // Relative vector legs for the current term
  logic signed [31:0] rk, rl;
  always_comb begin
    case (kx)
      2'd0:    rk = cur.rel_x;
      2'd1:    rk = cur.rel_y;
      default: rk = cur.rel_z;
    endcase
    case (lx)
      2'd0:    rl = cur.rel_x;
      2'd1:    rl = cur.rel_y;
      default: rl = cur.rel_z;
    endcase
  end

  assign acc_slot  = slot(a_co, b_co, kx, lx);
  assign last_term = (kx == 2'd2) && (lx == 2'd2);

  // Bracket slot for the current symmetry and part
  logic [7:0] pp;
  logic [1:0] ip, iq, ir, is;
  always_comb begin
    pp = sym_perm(perm_cnt);
    ip = ix[pp[7:6]];
    iq = ix[pp[5:4]];
    ir = ix[pp[3:2]];
    is = ix[pp[1:0]];
    case (part_cnt)
      2'd0:    read_slot = slot(ip, ir, iq, is);
      2'd1:    read_slot = slot(iq, ir, ip, is);
      default: read_slot = slot(ip, iq, ir, is);
    endcase
  end
  assign last_combo = (part_cnt == 2'd2) && (!sym_q || perm_cnt == 3'd7);

  // Term rounding: (p1*2^32 + p0 + 2^39) >> 40, signed by the signs of phi and both legs
  logic [95:0] rnd_total;
  logic [63:0] rnd_mag;
  logic        term_neg;
  always_comb begin
    rnd_total = {p1, 32'd0} + {32'd0, p0} + (96'd1 << 39);
    rnd_mag   = {8'd0, rnd_total[95:40]};
    term_neg  = cur.fc_value[31] ^ rk[31] ^ rl[31];
  end

  // Saturating add into the fetched sum
  logic signed [64:0] add_full;
  logic               add_sat;
  always_comb begin
    add_full = {rdata[63], rdata} + {term[63], term};
    add_sat  = (add_full[64] != add_full[63]);
    if (!add_sat) wdata = add_full[63:0];
    else if (add_full[64]) wdata = {1'b1, 63'd0};
    else wdata = {1'b0, {63{1'b1}}};
  end

  // Final rounding and saturation to 48 bits
  logic [103:0] fin_m;
  logic [103:0] fin_q;
  logic [103:0] fin_lim;
  logic         fin_sat;
  logic [47:0]  fin_round;
  logic [47:0]  fin_val;
  always_comb begin
    fin_m     = prod + (sym_q ? (104'd1 << 39) : (104'd1 << 36));
    fin_q     = sym_q ? (fin_m >> 40) : (fin_m >> 37);
    fin_lim   = neg_q ? (104'd1 << 47) : ((104'd1 << 47) - 104'd1);
    fin_sat   = (fin_q > fin_lim);
    fin_round = fin_sat ? fin_lim[47:0] : fin_q[47:0];
    fin_val   = neg_q ? 48'(-fin_round) : fin_round;
  end

  // Scale pass: one 24-bit slice of the magnitude per cycle
  logic [55:0]  chunk_prod;
  logic [103:0] chunk_sh;
  always_comb begin
    chunk_prod = {32'd0, mag[24*chunk_cnt +: 24]} * {24'd0, scale_factor};
    case (chunk_cnt)
      2'd0:    chunk_sh = {48'd0, chunk_prod};
      2'd1:    chunk_sh = {24'd0, chunk_prod, 24'd0};
      default: chunk_sh = {chunk_prod, 48'd0};
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state and store requests
  always_comb begin
    state_next = state;
    req        = '0;
    req.clr    = accept && (cmd.func == FUNC_CLEAR);
    case (state)
      ST_IDLE: begin
        if (accept && cmd.func == FUNC_ACC && acc_ok) state_next = ST_MUL1;
        else if (accept && cmd.func == FUNC_READ)     state_next = ST_RISSUE;
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_RND;
      ST_RND: begin
        req.rd     = 1'b1;
        req.addr   = acc_slot;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        req.wr     = 1'b1;
        req.addr   = acc_slot;
        state_next = last_term ? ST_IDLE : ST_MUL1;
      end
      ST_RISSUE: begin
        req.rd     = 1'b1;
        req.addr   = read_slot;
        state_next = ST_RACC;
      end
      ST_RACC: state_next = last_combo ? ST_FABS : ST_RISSUE;
      ST_FABS: state_next = ST_FMUL;
      ST_FMUL: state_next = (chunk_cnt == 2'd2) ? ST_FOUT : ST_FMUL;
      ST_FOUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur       <= cmd;
        a_co      <= mod3(cmd.first_index);
        b_co      <= mod3(cmd.second_index);
        kx        <= 2'd0;
        lx        <= 2'd0;
        sum_acc   <= '0;
        perm_cnt  <= 3'd0;
        part_cnt  <= 2'd0;
        sym_q     <= symmetrize_enable;
        ix[0]     <= clamp_idx(cmd.read_i);
        ix[1]     <= clamp_idx(cmd.read_j);
        ix[2]     <= clamp_idx(cmd.read_k);
        ix[3]     <= clamp_idx(cmd.read_l);
      end
      ST_MUL1: m1 <= mag32(cur.fc_value) * mag32(rk);
      ST_MUL2: p0 <= {32'd0, m1[31:0]} * {32'd0, mag32(rl)};
      ST_MUL3: p1 <= {32'd0, m1[63:32]} * {32'd0, mag32(rl)};
      ST_RND:  term <= term_neg ? -$signed(rnd_mag) : $signed(rnd_mag);
      ST_ADD: begin
        if (lx == 2'd2) begin
          lx <= 2'd0;
          kx <= kx + 2'd1;
        end else begin
          lx <= lx + 2'd1;
        end
      end
      ST_RACC: begin
        if (part_cnt == 2'd2)
          sum_acc <= sum_acc - {{8{rdata[63]}}, rdata};
        else
          sum_acc <= sum_acc + {{8{rdata[63]}}, rdata};
        if (part_cnt == 2'd2) begin
          part_cnt <= 2'd0;
          perm_cnt <= perm_cnt + 3'd1;
        end else begin
          part_cnt <= part_cnt + 2'd1;
        end
      end
      ST_FABS: begin
        neg_q     <= !sum_acc[71];
        mag       <= sum_acc[71] ? 72'(-sum_acc) : 72'(sum_acc);
        prod      <= '0;
        chunk_cnt <= 2'd0;
      end
      ST_FMUL: begin
        prod      <= prod + chunk_sh;
        chunk_cnt <= chunk_cnt + 2'd1;
      end
      default: ;
    endcase
  end

  // Sticky overflow flag
  always_ff @(posedge clk) begin
    if (rst || req.clr)                    overflow_seen <= 1'b0;
    else if (state == ST_ADD && add_sat)   overflow_seen <= 1'b1;
  end

  // Result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state == ST_FOUT);
    end
    if (state == ST_FOUT) begin
      result.elastic_value <= fin_val;
      result.saturated     <= overflow_seen || fin_sat;
    end
  end

  // Checks
  a_strobe_one: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("result strobe held longer than one cycle");

  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(state == ST_FOUT))
    else $error("result strobe without a finished read");

  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD) |-> $past(state == ST_RND))
    else $error("sum write without a preceding fetch");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.func == FUNC_CLEAR) |=> (!overflow_seen && !busy))
    else $error("clear item left overflow flag or busy set");

endmodule

@@ rtl/etfc_sum_store.sv @@
`timescale 1ns / 1ps

module etfc_sum_store (
  input  logic                            clk,
  input  logic                            rst,
  input  etfc_pkg::mem_req_t              req,
  input  logic [etfc_pkg::SUM_W-1:0]      wdata,
  output logic [etfc_pkg::SUM_W-1:0]      rdata
);
  import etfc_pkg::*;

  logic [SUM_W-1:0]     mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid;
  logic [SUM_W-1:0]     rd_q;
  logic                 vld_q;

  // Sum array, registered read
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= wdata;
    end
    if (req.rd) begin
      rd_q <= mem[req.addr];
    end
  end

  // Entry valid bits; an entry not written since clear reads as zero
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (req.wr) valid[req.addr] <= 1'b1;
      if (req.rd) vld_q <= valid[req.addr];
    end
  end

  assign rdata = vld_q ? rd_q : '0;

endmodule
